### rtl/dpsrs_pkg.sv
package dpsrs_pkg;

	// Default ring depths, handed to the top-level parameters.
	localparam int MAIN_DEPTH_DEF   = 2048;
	localparam int SECOND_DEPTH_DEF = 4096;

	// Fixed field and register widths.
	localparam int SAMPLE_W     = 16;
	localparam int KIND_W       = 3;
	localparam int MAIN_LEN_W   = 12;
	localparam int SECOND_LEN_W = 13;
	localparam int DECAY_W      = 16;
	localparam int PADDR_W      = 4;
	localparam int PDATA_W      = 32;

	// Register values after reset.
	localparam logic [MAIN_LEN_W-1:0]   MAIN_LEN_RST   = 12'd100;
	localparam logic [SECOND_LEN_W-1:0] SECOND_LEN_RST = 13'd200;
	localparam logic                    SECOND_ACT_RST = 1'b0;
	localparam logic [DECAY_W-1:0]      DECAY_RST      = 16'd32636;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR       = 3'd0,
		KIND_LOAD_MAIN   = 3'd1,
		KIND_LOAD_SECOND = 3'd2,
		KIND_TICK        = 3'd3,
		KIND_READ        = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		REG_MAIN_LENGTH   = 2'd0,
		REG_SECOND_LENGTH = 2'd1,
		REG_SECOND_ACTIVE = 2'd2,
		REG_DECAY_FACTOR  = 2'd3
	} reg_idx_t;

	// Command to one ring, already qualified by the input handshake.
	typedef struct packed {
		logic clear;
		logic load;
		logic tick;
	} ring_cmd_t;

	// Ring status seen by the top level while a word is accepted.
	typedef struct packed {
		logic occupied;    // ring holds at least one sample now
		logic full_after;  // ring counts as full once this word has acted
	} ring_stat_t;

endpackage

### rtl/dpsrs_ring.sv
module dpsrs_ring #(
	parameter int DEPTH = dpsrs_pkg::MAIN_DEPTH_DEF,
	parameter int LEN_W = dpsrs_pkg::MAIN_LEN_W
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic [LEN_W-1:0]                        len_reg,
	input  logic [dpsrs_pkg::DECAY_W-1:0]           decay,
	input  dpsrs_pkg::ring_cmd_t                    cmd,
	input  logic signed [dpsrs_pkg::SAMPLE_W-1:0]   load_value,
	output dpsrs_pkg::ring_stat_t                   stat,
	output logic signed [dpsrs_pkg::SAMPLE_W-1:0]   front
);
	import dpsrs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int WW = (CW > LEN_W) ? CW : LEN_W;

	// Adds an offset of at most DEPTH to a ring index and wraps it once.
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return AW'(sum);
	endfunction

	// Sum of two samples scaled by an unsigned Q0.16 factor, truncated toward
	// zero and saturated to the sample range.
	function automatic logic [SAMPLE_W-1:0] decay_sum(input logic [SAMPLE_W-1:0] a,
			input logic [SAMPLE_W-1:0] b, input logic [DECAY_W-1:0] f);
		logic [SAMPLE_W:0]           s;
		logic [SAMPLE_W:0]           mag;
		logic [SAMPLE_W+DECAY_W:0]   prod;
		logic [SAMPLE_W:0]           q;
		logic [SAMPLE_W:0]           neg;
		logic [SAMPLE_W-1:0]         res;
		s    = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
		mag  = s[SAMPLE_W] ? (~s + (SAMPLE_W+1)'(1)) : s;
		prod = (SAMPLE_W+DECAY_W+1)'(mag) * (SAMPLE_W+DECAY_W+1)'(f);
		q    = prod[SAMPLE_W+DECAY_W:DECAY_W];
		neg  = ~q + (SAMPLE_W+1)'(1);
		if (!s[SAMPLE_W]) begin
			res = (q > (SAMPLE_W+1)'(32767)) ? 16'h7FFF : q[SAMPLE_W-1:0];
		end else begin
			res = (q > (SAMPLE_W+1)'(32768)) ? 16'h8000 : neg[SAMPLE_W-1:0];
		end
		return res;
	endfunction

	logic [SAMPLE_W-1:0] mem [DEPTH];

	logic [AW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       head_d;
	logic [CW-1:0]       count_d;
	logic [CW-1:0]       elen;
	logic [WW-1:0]       len_ext;
	logic                is_full;
	logic [AW-1:0]       head_inc;
	logic [AW-1:0]       tail_addr;

	logic                tick_s1;
	logic                load_s1;
	logic [AW-1:0]       waddr_s1;
	logic [AW-1:0]       ra_s1;
	logic [AW-1:0]       rb_s1;
	logic [SAMPLE_W-1:0] val_s1;
	logic [SAMPLE_W-1:0] rd_a_s1;
	logic [SAMPLE_W-1:0] rd_b_s1;

	logic                fwd_we_q;
	logic [AW-1:0]       fwd_addr_q;
	logic [SAMPLE_W-1:0] fwd_data_q;

	logic [SAMPLE_W-1:0] fa;
	logic [SAMPLE_W-1:0] fb;
	logic [SAMPLE_W-1:0] wdata;
	logic                we;

	// Length register saturated to the range 2 .. DEPTH.
	always_comb begin
		len_ext = WW'(len_reg);
		if (len_ext < WW'(2)) begin
			elen = CW'(2);
		end else if (len_ext > WW'(DEPTH)) begin
			elen = CW'(DEPTH);
		end else begin
			elen = CW'(len_ext);
		end
	end

	assign is_full   = count_q >= elen;
	assign head_inc  = wrap_add(head_q, CW'(1));
	assign tail_addr = wrap_add(head_q, count_q);

	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		if (cmd.clear) begin
			head_d  = '0;
			count_d = '0;
		end else if (cmd.load && !is_full) begin
			count_d = count_q + CW'(1);
		end else if (cmd.tick && is_full) begin
			head_d = head_inc;
		end
	end

	assign stat.occupied   = count_q != '0;
	assign stat.full_after = count_d >= elen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			tick_s1  <= 1'b0;
			load_s1  <= 1'b0;
			fwd_we_q <= 1'b0;
		end else begin
			head_q   <= head_d;
			count_q  <= count_d;
			tick_s1  <= cmd.tick && is_full;
			load_s1  <= cmd.load && !is_full;
			fwd_we_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1   <= tail_addr;
		ra_s1      <= head_q;
		rb_s1      <= head_inc;
		val_s1     <= load_value;
		fwd_addr_q <= waddr_s1;
		fwd_data_q <= wdata;
	end

	// The word written in the previous cycle is not yet visible in the read
	// data, so it is forwarded here.
	assign fa = (fwd_we_q && fwd_addr_q == ra_s1) ? fwd_data_q : rd_a_s1;
	assign fb = (fwd_we_q && fwd_addr_q == rb_s1) ? fwd_data_q : rd_b_s1;

	assign we    = tick_s1 || load_s1;
	assign wdata = tick_s1 ? decay_sum(fa, fb, decay) : val_s1;
	assign front = fa;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr_s1] <= wdata;
		end
		rd_a_s1 <= mem[head_q];
		rd_b_s1 <= mem[head_inc];
	end

endmodule

### rtl/dual_plucked_string_ring_synth.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid / in_ready      kind, load_value
// out       output     out_valid / out_ready    sample_out, main_full
// config    input      psel, penable, pwrite    paddr, pwdata -> prdata, pready
//
// One word is accepted every clock cycle while in_ready is high. Its result passes
// through stage 1 into the output queue, where it waits until the output side is free.
// The rate is set by the one write port of each ring memory: each word writes at
// most one entry per ring, and all writes happen in the stage after acceptance.
// Reset clears ring heads, fill counts, the interleave phase and the pipeline;
// ring memory contents are undefined until written, and there is no clearing pass.
// A four-entry output queue absorbs output stalls; in_ready drops once the queue
// plus the word in flight would fill it.
module dual_plucked_string_ring_synth #(
	parameter int MAIN_DEPTH   = dpsrs_pkg::MAIN_DEPTH_DEF,
	parameter int SECOND_DEPTH = dpsrs_pkg::SECOND_DEPTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [dpsrs_pkg::KIND_W-1:0]            kind,
	input  logic signed [dpsrs_pkg::SAMPLE_W-1:0]   load_value,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [dpsrs_pkg::SAMPLE_W-1:0]   sample_out,
	output logic                                    main_full,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [dpsrs_pkg::PADDR_W-1:0]           paddr,
	input  logic [dpsrs_pkg::PDATA_W-1:0]           pwdata,
	output logic [dpsrs_pkg::PDATA_W-1:0]           prdata,
	output logic                                    pready
);
	import dpsrs_pkg::*;

	// Output queue geometry.
	localparam int QD  = 4;
	localparam int QAW = $clog2(QD);
	localparam int QCW = $clog2(QD + 1);

	// Configuration registers.
	logic [MAIN_LEN_W-1:0]   main_length_q;
	logic [SECOND_LEN_W-1:0] second_length_q;
	logic                    second_active_q;
	logic [DECAY_W-1:0]      decay_q;
	logic                    cfg_wr;
	reg_idx_t                cfg_idx;

	// The register index comes from the word address; pready is tied high so
	// every access completes in its access phase.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_length_q   <= MAIN_LEN_RST;
			second_length_q <= SECOND_LEN_RST;
			second_active_q <= SECOND_ACT_RST;
			decay_q         <= DECAY_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MAIN_LENGTH:   main_length_q   <= pwdata[MAIN_LEN_W-1:0];
				REG_SECOND_LENGTH: second_length_q <= pwdata[SECOND_LEN_W-1:0];
				REG_SECOND_ACTIVE: second_active_q <= pwdata[0];
				REG_DECAY_FACTOR:  decay_q         <= pwdata[DECAY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_MAIN_LENGTH:   prdata = PDATA_W'(main_length_q);
			REG_SECOND_LENGTH: prdata = PDATA_W'(second_length_q);
			REG_SECOND_ACTIVE: prdata = PDATA_W'(second_active_q);
			REG_DECAY_FACTOR:  prdata = PDATA_W'(decay_q);
			default:           prdata = '0;
		endcase
	end

	// Stage 0: decode the accepted word. Ring heads and counts advance here,
	// and both ring memories are read at the head and the entry after it.
	logic        accept;
	ring_cmd_t   main_cmd;
	ring_cmd_t   second_cmd;
	ring_stat_t  main_stat;
	ring_stat_t  second_stat;
	logic        rd_main;
	logic        rd_second;
	logic        phase_adv;
	logic [1:0]  phase_q;

	assign accept = in_valid && in_ready;

	always_comb begin
		main_cmd   = '0;
		second_cmd = '0;
		rd_main    = 1'b0;
		rd_second  = 1'b0;
		phase_adv  = 1'b0;
		case (kind_t'(kind))
			KIND_CLEAR: begin
				main_cmd.clear   = accept;
				second_cmd.clear = accept;
			end
			KIND_LOAD_MAIN: begin
				main_cmd.load = accept;
			end
			KIND_LOAD_SECOND: begin
				second_cmd.load = accept;
			end
			KIND_TICK: begin
				main_cmd.tick   = accept;
				second_cmd.tick = accept && second_active_q;
			end
			KIND_READ: begin
				// An empty main ring yields zero. With the second ring enabled
				// and holding data, reads alternate two main, two second.
				if (main_stat.occupied) begin
					if (second_active_q && second_stat.occupied) begin
						rd_second = phase_q[1];
						rd_main   = !phase_q[1];
						phase_adv = accept;
					end else begin
						rd_main = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Stage 1: read data is back, forwarded where needed; tick results and
	// loads are written into the rings, and the result word is formed.
	logic                       s1_valid_s1;
	logic                       rd_main_s1;
	logic                       rd_second_s1;
	logic                       full_s1;
	logic signed [SAMPLE_W-1:0] main_front;
	logic signed [SAMPLE_W-1:0] second_front;
	logic signed [SAMPLE_W-1:0] sample_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			s1_valid_s1  <= 1'b0;
			rd_main_s1   <= 1'b0;
			rd_second_s1 <= 1'b0;
		end else begin
			if (phase_adv) begin
				phase_q <= phase_q + 2'd1;
			end
			s1_valid_s1  <= accept;
			rd_main_s1   <= accept && rd_main;
			rd_second_s1 <= accept && rd_second;
		end
	end

	always_ff @(posedge clk) begin
		full_s1 <= main_stat.full_after;
	end

	dpsrs_ring #(
		.DEPTH (MAIN_DEPTH),
		.LEN_W (MAIN_LEN_W)
	) u_main (
		.clk        (clk),
		.arst_n     (arst_n),
		.len_reg    (main_length_q),
		.decay      (decay_q),
		.cmd        (main_cmd),
		.load_value (load_value),
		.stat       (main_stat),
		.front      (main_front)
	);

	dpsrs_ring #(
		.DEPTH (SECOND_DEPTH),
		.LEN_W (SECOND_LEN_W)
	) u_second (
		.clk        (clk),
		.arst_n     (arst_n),
		.len_reg    (second_length_q),
		.decay      (decay_q),
		.cmd        (second_cmd),
		.load_value (load_value),
		.stat       (second_stat),
		.front      (second_front)
	);

	assign sample_s1 = rd_main_s1   ? main_front   :
	                   rd_second_s1 ? second_front : '0;

	// Output queue: stage 1 always drains into it, so input ready is judged on
	// the queue fill plus the word in flight.
	logic [SAMPLE_W-1:0] q_sample_q [QD];
	logic                q_full_q   [QD];
	logic [QAW-1:0]      wr_ptr_q;
	logic [QAW-1:0]      rd_ptr_q;
	logic [QCW-1:0]      q_cnt_q;
	logic [QCW:0]        occ;
	logic                pop;

	assign occ       = (QCW+1)'(q_cnt_q) + (QCW+1)'(s1_valid_s1);
	assign in_ready  = occ < (QCW+1)'(QD);
	assign out_valid = q_cnt_q != '0;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (s1_valid_s1) begin
			q_sample_q[wr_ptr_q] <= sample_s1;
			q_full_q[wr_ptr_q]   <= full_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			q_cnt_q  <= '0;
		end else begin
			if (s1_valid_s1) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({s1_valid_s1, pop})
				2'b10:   q_cnt_q <= q_cnt_q + QCW'(1);
				2'b01:   q_cnt_q <= q_cnt_q - QCW'(1);
				default: q_cnt_q <= q_cnt_q;
			endcase
		end
	end

	assign sample_out = q_sample_q[rd_ptr_q];
	assign main_full  = q_full_q[rd_ptr_q];

	// Every accepted word reaches stage 1 in the next cycle.
	a_s1_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> s1_valid_s1)
		else $error("accepted word did not reach stage 1");

	// Queue fill plus the word in flight never exceeds the queue depth.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= (QCW+1)'(QD))
		else $error("output queue overrun");

	// A read selects at most one ring front.
	a_one_front: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({rd_main_s1, rd_second_s1}))
		else $error("both ring fronts selected");

endmodule

### sim/tb_dual_plucked_string_ring_synth.sv
`timescale 1ns / 100ps

// Testbench for the dual plucked-string ring synthesizer.
// An initial block builds the stimulus one configuration phase at a time and
// places the words in a queue. A clocked driver offers them on the input
// channel. At acceptance, a predictor computes the expected result and
// appends it to a queue. A clocked monitor takes results with random stalls
// and compares each one with the oldest expectation.
module tb_dual_plucked_string_ring_synth;
	import dpsrs_pkg::*;

	localparam int unsigned MAIN_RING_DEPTH   = MAIN_DEPTH_DEF;
	localparam int unsigned SECOND_RING_DEPTH = SECOND_DEPTH_DEF;

	// Kind codes that the block must ignore.
	localparam logic [KIND_W-1:0] KIND_NONE_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_NONE_LAST  = 3'd7;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
	localparam logic [DECAY_W-1:0]  DECAY_MAX  = 16'hFFFF;
	localparam logic [DECAY_W-1:0]  DECAY_ZERO = 16'h0000;

	// Register values that lie above the ring depths, so the block must
	// saturate them to 2048 and 4096.
	localparam logic [MAIN_LEN_W-1:0]   MAIN_LEN_OVER   = 12'hFFF;
	localparam logic [SECOND_LEN_W-1:0] SECOND_LEN_OVER = 13'h1FFF;

	localparam int unsigned RANDOM_WORDS    = 1650;
	localparam int unsigned PRESSURE_PHASE  = 7;
	localparam int unsigned LARGE_PHASE     = 5;
	localparam int unsigned LARGE_FILL      = 150;
	localparam int unsigned PRESSURE_CYCLES = 250;
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam int unsigned CYCLE_LIMIT     = 1500000;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [SAMPLE_W-1:0] value;
	} synth_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       full;
	} synth_result_t;

	// Block ports. Every input starts at a known value.
	logic                        clk        = 1'b0;
	logic                        arst_n     = 1'b0;
	logic                        in_valid   = 1'b0;
	logic                        in_ready;
	logic [KIND_W-1:0]           kind       = '0;
	logic signed [SAMPLE_W-1:0]  load_value = '0;
	logic                        out_valid;
	logic                        out_ready  = 1'b0;
	logic signed [SAMPLE_W-1:0]  sample_out;
	logic                        main_full;
	logic                        psel       = 1'b0;
	logic                        penable    = 1'b0;
	logic                        pwrite     = 1'b0;
	logic [PADDR_W-1:0]          paddr      = '0;
	logic [PDATA_W-1:0]          pwdata     = '0;
	logic [PDATA_W-1:0]          prdata;
	logic                        pready;

	// Words waiting to be offered, and results the block still owes.
	synth_word_t   pending_words[$];
	synth_result_t expected_results[$];

	// Predictor state: its own copy of both rings and of the registers.
	logic [SAMPLE_W-1:0] main_samples[MAIN_RING_DEPTH];
	logic [SAMPLE_W-1:0] second_samples[SECOND_RING_DEPTH];
	int unsigned         main_front   = 0;
	int unsigned         main_fill    = 0;
	int unsigned         second_front = 0;
	int unsigned         second_fill  = 0;
	logic [1:0]          read_phase   = '0;

	logic [MAIN_LEN_W-1:0]   main_len_reg   = MAIN_LEN_RST;
	logic [SECOND_LEN_W-1:0] second_len_reg = SECOND_LEN_RST;
	logic                    second_on_reg  = SECOND_ACT_RST;
	logic [DECAY_W-1:0]      decay_reg      = DECAY_RST;

	// Run bookkeeping.
	int unsigned error_count         = 0;
	int unsigned words_accepted      = 0;
	int unsigned words_queued        = 0;
	int unsigned results_checked     = 0;
	int unsigned second_ring_reads   = 0;
	int unsigned backpressure_cycles = 0;
	int unsigned cycle_count         = 0;
	int unsigned src_wait            = 0;
	int unsigned sink_wait           = 0;
	bit          src_steady          = 1'b0;
	bit          sink_steady         = 1'b0;
	bit          pressure_req        = 1'b0;
	bit          pressure_done       = 1'b0;

	dual_plucked_string_ring_synth u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.load_value (load_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.main_full  (main_full),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #10 clk = ~clk;

	// The length registers count as 2 below 2 and as the ring depth above it.
	function automatic int unsigned clamp_len(int unsigned len_val, int unsigned depth);
		if (len_val < 2) return 2;
		if (len_val > depth) return depth;
		return len_val;
	endfunction

	// One string step: the sum of two neighbors is scaled by the unsigned
	// Q0.16 decay. The magnitude is scaled so that the result truncates
	// toward zero, and the result is then saturated to 16 bits.
	function automatic logic [SAMPLE_W-1:0] decayed_sum(logic [SAMPLE_W-1:0] a,
			logic [SAMPLE_W-1:0] b, logic [DECAY_W-1:0] factor);
		longint sum;
		longint scaled;
		sum = longint'($signed(a)) + longint'($signed(b));
		scaled = ((sum < 0) ? -sum : sum) * longint'(factor);
		scaled = scaled >>> 16;
		if (sum < 0) scaled = -scaled;
		if (scaled > 32767) scaled = 32767;
		if (scaled < -32768) scaled = -32768;
		return SAMPLE_W'(scaled);
	endfunction

	// This function advances the predictor by one accepted word and returns
	// the result that the word must produce.
	function automatic synth_result_t predict_word(logic [KIND_W-1:0] k,
			logic [SAMPLE_W-1:0] v);
		synth_result_t r;
		int unsigned   mlen;
		int unsigned   slen;
		int unsigned   h;
		int unsigned   nx;
		mlen = clamp_len(main_len_reg, MAIN_RING_DEPTH);
		slen = clamp_len(second_len_reg, SECOND_RING_DEPTH);
		r.sample = '0;
		case (k)
			KIND_CLEAR: begin
				main_front = 0;
				main_fill = 0;
				second_front = 0;
				second_fill = 0;
			end
			KIND_LOAD_MAIN: begin
				if (main_fill < mlen) begin
					main_samples[(main_front + main_fill) % MAIN_RING_DEPTH] = v;
					main_fill++;
				end
			end
			KIND_LOAD_SECOND: begin
				if (second_fill < slen) begin
					second_samples[(second_front + second_fill) % SECOND_RING_DEPTH] = v;
					second_fill++;
				end
			end
			KIND_TICK: begin
				if (main_fill >= mlen) begin
					h = main_front % MAIN_RING_DEPTH;
					nx = (h + 1) % MAIN_RING_DEPTH;
					main_samples[(h + main_fill) % MAIN_RING_DEPTH] =
						decayed_sum(main_samples[h], main_samples[nx], decay_reg);
					main_front = nx;
				end
				if (second_on_reg && second_fill >= slen) begin
					h = second_front % SECOND_RING_DEPTH;
					nx = (h + 1) % SECOND_RING_DEPTH;
					second_samples[(h + second_fill) % SECOND_RING_DEPTH] =
						decayed_sum(second_samples[h], second_samples[nx], decay_reg);
					second_front = nx;
				end
			end
			KIND_READ: begin
				if (main_fill != 0) begin
					if (second_on_reg && second_fill != 0) begin
						if (read_phase < 2) begin
							r.sample = main_samples[main_front % MAIN_RING_DEPTH];
						end else begin
							r.sample = second_samples[second_front % SECOND_RING_DEPTH];
							second_ring_reads++;
						end
						read_phase = read_phase + 2'd1;
					end else begin
						r.sample = main_samples[main_front % MAIN_RING_DEPTH];
					end
				end
			end
			default: begin
			end
		endcase
		r.full = (main_fill >= mlen);
		return r;
	endfunction

	// Gap lengths are mostly zero or short, with a few long ones.
	function automatic int unsigned pick_gap(bit steady);
		int unsigned roll;
		if (steady) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 12);
		return $urandom_range(16, 40);
	endfunction

	// The input driver offers queued words, holding each one until it is
	// accepted. At acceptance the predictor runs on the word that was held.
	always @(posedge clk or negedge arst_n) begin : word_driver
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= '0;
			load_value <= '0;
			src_wait <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_word(kind, load_value));
				words_accepted++;
			end
			if (in_valid && !in_ready) begin
				backpressure_cycles++;
			end else if (src_wait != 0) begin
				in_valid <= 1'b0;
				src_wait <= src_wait - 1;
			end else if (pending_words.size() != 0) begin
				in_valid <= 1'b1;
				kind <= pending_words[0].kind;
				load_value <= pending_words[0].value;
				pending_words.delete(0);
				src_wait <= pick_gap(src_steady);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// The result monitor checks each accepted result against the oldest
	// expectation. It also drives out_ready. Once in the run it holds off for
	// a long stretch, so that the output queue fills and in_ready drops.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		synth_result_t want;
		int unsigned   gap;
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_wait <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no word outstanding: sample_out %0d main_full %0b",
						sample_out, main_full);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (sample_out !== want.sample) begin
						$error("sample_out: expected %0d, actual %0d", want.sample, sample_out);
						error_count++;
					end
					if (main_full !== want.full) begin
						$error("main_full: expected %0b, actual %0b", want.full, main_full);
						error_count++;
					end
					results_checked++;
				end
			end
			if (pressure_req && !pressure_done) begin
				pressure_done = 1'b1;
				out_ready <= 1'b0;
				sink_wait <= PRESSURE_CYCLES;
			end else if (sink_wait != 0) begin
				out_ready <= 1'b0;
				sink_wait <= sink_wait - 1;
			end else begin
				gap = pick_gap(sink_steady);
				out_ready <= (gap == 0);
				if (gap != 0) sink_wait <= gap - 1;
			end
		end
	end

	// This is a watchdog for a block that hangs or loses results.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_word(logic [KIND_W-1:0] k, logic [SAMPLE_W-1:0] v);
		pending_words.push_back('{kind: k, value: v});
		if (k <= KIND_READ) words_queued++;
	endtask

	// About one sample in ten is an extreme value, so that sums saturate.
	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 19))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// This task waits until no word is queued, offered or owed, and then
	// lets the pipeline settle. Sampling on the falling edge keeps the check
	// clear of the driver's updates.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// A register write has a setup phase and an access phase. A read of the
	// same address follows at once, and its data is checked during the access
	// phase.
	task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== val) begin
			$error("prdata of %s: expected %0d, actual %0d", idx.name(), val, prdata);
			error_count++;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// All four registers are written. The predictor takes the new values
	// only now, while the block is idle.
	task automatic configure(logic [MAIN_LEN_W-1:0] mlen, logic [SECOND_LEN_W-1:0] slen,
			logic act, logic [DECAY_W-1:0] decay);
		write_reg(REG_MAIN_LENGTH, PDATA_W'(mlen));
		write_reg(REG_SECOND_LENGTH, PDATA_W'(slen));
		write_reg(REG_SECOND_ACTIVE, PDATA_W'(act));
		write_reg(REG_DECAY_FACTOR, PDATA_W'(decay));
		main_len_reg = mlen;
		second_len_reg = slen;
		second_on_reg = act;
		decay_reg = decay;
	endtask

	// One phase is an optional clear, then both rings filled in random
	// order, at most fill_cap loads each, with a few reads, ticks and junk
	// kinds mixed in. After that comes a run of mostly ticks and reads.
	task automatic run_phase(bit with_clear, int unsigned tail, int unsigned fill_cap);
		int unsigned ml;
		int unsigned sl;
		int unsigned main_left;
		int unsigned second_left;
		int unsigned roll;
		ml = clamp_len(main_len_reg, MAIN_RING_DEPTH);
		sl = clamp_len(second_len_reg, SECOND_RING_DEPTH);
		if (with_clear) push_word(KIND_CLEAR, rand_sample());
		main_left = ml + $urandom_range(0, 2);
		second_left = sl + $urandom_range(0, 2);
		if ($urandom_range(0, 9) == 0) second_left = $urandom_range(0, sl);
		if (main_left > fill_cap) main_left = fill_cap;
		if (second_left > fill_cap) second_left = fill_cap;
		while (main_left + second_left != 0) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				push_word(KIND_READ, rand_sample());
			end else if (roll < 12) begin
				push_word(KIND_TICK, rand_sample());
			end else if (roll < 13) begin
				push_word(KIND_W'($urandom_range(KIND_NONE_FIRST, KIND_NONE_LAST)), rand_sample());
			end else if (second_left == 0 || (main_left != 0 && $urandom_range(0, 1) == 1)) begin
				push_word(KIND_LOAD_MAIN, rand_sample());
				main_left--;
			end else begin
				push_word(KIND_LOAD_SECOND, rand_sample());
				second_left--;
			end
		end
		repeat (tail) begin
			roll = $urandom_range(0, 999);
			if (roll < 500) push_word(KIND_TICK, rand_sample());
			else if (roll < 880) push_word(KIND_READ, rand_sample());
			else if (roll < 920) push_word(KIND_LOAD_MAIN, rand_sample());
			else if (roll < 950) push_word(KIND_LOAD_SECOND, rand_sample());
			else if (roll < 995)
				push_word(KIND_W'($urandom_range(KIND_NONE_FIRST, KIND_NONE_LAST)), rand_sample());
			else push_word(KIND_CLEAR, rand_sample());
		end
	endtask

	initial begin
		int unsigned random_words;
		int unsigned phase_idx;
		int unsigned queued_at_start;
		int unsigned fill_cap;
		bit          keep_fill;
		random_words = 0;
		phase_idx = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The first words use the registers as they come out of reset.
		// They read an empty main ring, tick a ring that is not full, and
		// read a ring that is only partly loaded.
		push_word(KIND_READ, SAMPLE_MAX);
		push_word(KIND_TICK, SAMPLE_MIN);
		push_word(KIND_LOAD_MAIN, 16'sd7);
		push_word(KIND_READ, '0);
		wait_drained();

		// With two-sample rings and the largest decay, both ticks saturate:
		// the main ring at the positive limit and the second at the negative
		// limit. Five reads walk the interleave phase once round and one step
		// further. The final reads after a clear show that a cleared second ring
		// stops the interleaving.
		configure(12'd2, 13'd2, 1'b1, DECAY_MAX);
		push_word(KIND_CLEAR, '0);
		push_word(KIND_NONE_FIRST, SAMPLE_MIN);
		push_word(KIND_NONE_FIRST + 3'd1, '1);
		push_word(KIND_NONE_LAST, SAMPLE_MAX);
		push_word(KIND_LOAD_MAIN, SAMPLE_MAX);
		push_word(KIND_LOAD_MAIN, SAMPLE_MAX);
		push_word(KIND_LOAD_MAIN, '1);
		push_word(KIND_LOAD_SECOND, SAMPLE_MIN);
		push_word(KIND_LOAD_SECOND, SAMPLE_MIN);
		push_word(KIND_LOAD_SECOND, 16'sd5);
		repeat (5) push_word(KIND_READ, '0);
		push_word(KIND_TICK, '0);
		repeat (4) push_word(KIND_READ, '0);
		push_word(KIND_TICK, '0);
		push_word(KIND_CLEAR, '0);
		push_word(KIND_READ, '0);
		push_word(KIND_LOAD_MAIN, 16'sd1);
		push_word(KIND_READ, '0);

		// The random phases start with fixed settings. These cover zero and
		// full decay and lengths below the minimum. One phase lowers the
		// lengths under the fill level without a clear. Another sets both
		// registers above range and loads a long run of samples; the
		// saturated lengths are too long for that run, so neither ring may
		// count as full. After those, the settings are random. Most lengths
		// stay short so that the rings fill and tick many times.
		while (random_words < RANDOM_WORDS) begin
			wait_drained();
			src_steady = (phase_idx % 4 == 3);
			sink_steady = (phase_idx % 5 == 2);
			keep_fill = 1'b0;
			fill_cap = SECOND_RING_DEPTH + 2;
			case (phase_idx)
				0: configure(12'd3, 13'd5, 1'b1, DECAY_ZERO);
				1: configure(12'd4, 13'd2, 1'b1, DECAY_MAX);
				2: configure(12'd0, 13'd1, 1'b1, DECAY_RST);
				3: configure(12'd8, 13'd8, 1'b1, DECAY_W'($urandom));
				4: begin
					configure(12'd3, 13'd3, 1'b1, DECAY_W'($urandom));
					keep_fill = 1'b1;
				end
				LARGE_PHASE: begin
					configure(MAIN_LEN_OVER, SECOND_LEN_OVER, 1'b1,
						DECAY_W'($urandom_range(60000, 65535)));
					fill_cap = LARGE_FILL;
				end
				default: configure(
					($urandom_range(0, 9) == 0) ? MAIN_LEN_W'($urandom_range(0, 1)) :
					($urandom_range(0, 5) == 0) ? MAIN_LEN_W'($urandom_range(25, 150)) :
					MAIN_LEN_W'($urandom_range(2, 24)),
					($urandom_range(0, 9) == 0) ? SECOND_LEN_W'($urandom_range(0, 1)) :
					($urandom_range(0, 5) == 0) ? SECOND_LEN_W'($urandom_range(25, 300)) :
					SECOND_LEN_W'($urandom_range(2, 24)),
					($urandom_range(0, 3) != 0),
					($urandom_range(0, 9) == 0) ? DECAY_ZERO :
					($urandom_range(0, 8) == 0) ? DECAY_MAX :
					($urandom_range(0, 1) == 0) ? DECAY_W'($urandom_range(58000, 65535)) :
					DECAY_W'($urandom));
			endcase
			queued_at_start = words_queued;
			run_phase(!keep_fill, $urandom_range(40, 120), fill_cap);
			if (phase_idx == PRESSURE_PHASE) pressure_req = 1'b1;
			random_words += words_queued - queued_at_start;
			phase_idx++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d results from %0d words over %0d phases.", results_checked,
			words_accepted, phase_idx + 2);
		$display("%0d reads came from the second ring; the input was held off for %0d cycles.",
			second_ring_reads, backpressure_cycles);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
